/* src/swo_pkg.sv */
`default_nettype none

package swo_pkg;

	// Defaults for the build parameters
	localparam int SineTableBitsDef = 10;
	localparam int SampleBitsDef    = 16;

	// Register map of the configuration channel
	localparam int CfgIndexW = 2;
	typedef enum logic [CfgIndexW-1:0] {
		REG_PHASE_STEP    = 2'd0,
		REG_PERIOD_LENGTH = 2'd1,
		REG_AMPLITUDE     = 2'd2
	} swo_reg_t;

	localparam int PhaseW  = 32;
	localparam int PeriodW = 16;
	localparam int AmpW    = 15;

	localparam logic [PhaseW-1:0]  PhaseStepRst    = 32'd2141543;
	localparam logic [PeriodW-1:0] PeriodLengthRst = 16'd100;
	localparam logic [AmpW-1:0]    AmplitudeRst    = 15'd32767;

	// Q30 constants for building the sine table at elaboration
	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
	localparam logic [63:0] OneQ30    = 64'd1 << 30;
	localparam logic [63:0] TaylorDiv [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// Control that travels with an item down the pipeline
	typedef struct packed {
		logic valid;
		logic start;
	} swo_ctl_t;

	// Sine of a Q30 angle, Taylor series to the fifteenth power, clamped to 0..1
	function automatic logic [63:0] sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / TaylorDiv[n];
			if (n % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (longint'(OneQ30) < sum)
			sum = longint'(OneQ30);
		return 64'(sum);
	endfunction

	// One quarter-wave table entry, scaled to full scale and rounded
	function automatic logic [63:0] sine_entry(input int k, input int table_bits,
		input int sample_bits);
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] fs;
		logic [63:0] v;
		x  = (64'(k) * HalfPiQ30) >> (table_bits - 2);
		s  = sine_q30(x);
		fs = (64'd1 << (sample_bits - 1)) - 64'd1;
		v  = (s * fs + (OneQ30 >> 1)) >> 30;
		if (v > fs)
			v = fs;
		return v;
	endfunction

endpackage

`default_nettype wire

/* src/swo_phase.sv */
`default_nettype none

module swo_phase
	import swo_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SineTableBitsDef
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic                       item,
	input  wire logic [PhaseW-1:0]          phase_step,
	input  wire logic [PeriodW-1:0]         period_length,
	output swo_ctl_t                        ctl_s1,
	output logic      [SINE_TABLE_BITS-1:0] idx_s1
);

	logic [PeriodW-1:0] position_q;
	logic [PhaseW-1:0]  phase_q;
	logic               wrap;
	logic [PeriodW-1:0] pos_use;
	logic [PhaseW-1:0]  phase_use;

	// Clear position and phase before the sample when the period has run out
	assign wrap      = position_q >= period_length;
	assign pos_use   = wrap ? '0 : position_q;
	assign phase_use = wrap ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			phase_q      <= '0;
			ctl_s1.valid <= 1'b0;
			ctl_s1.start <= 1'b0;
			idx_s1       <= '0;
		end else if (load) begin
			ctl_s1.valid <= item;
			if (item) begin
				position_q   <= pos_use + PeriodW'(1);
				phase_q      <= phase_use + phase_step;
				ctl_s1.start <= (pos_use == '0);
				idx_s1       <= phase_use[PhaseW-1 -: SINE_TABLE_BITS];
			end
		end
	end

endmodule

`default_nettype wire

/* src/swo_rom.sv */
`default_nettype none

module swo_rom
	import swo_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SineTableBitsDef,
	parameter int SAMPLE_BITS     = SampleBitsDef
) (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [SINE_TABLE_BITS-2:0] rd_addr,
	output logic      [SAMPLE_BITS-2:0]     rd_data
);

	localparam int Quarter = 1 << (SINE_TABLE_BITS - 2);

	typedef logic [SAMPLE_BITS-2:0] rom_arr_t [0:Quarter];

	function automatic rom_arr_t rom_fill();
		rom_arr_t r;
		for (int k = 0; k <= Quarter; k++)
			r[k] = (SAMPLE_BITS-1)'(sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS));
		return r;
	endfunction

	localparam rom_arr_t RomC = rom_fill();

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= RomC[rd_addr];
	end

endmodule

`default_nettype wire

/* src/swo_scale.sv */
`default_nettype none

module swo_scale
	import swo_pkg::*;
#(
	parameter int SAMPLE_BITS = SampleBitsDef
) (
	input  wire logic                   clk,
	input  wire logic                   load,
	input  wire logic [SAMPLE_BITS-2:0] mag,
	input  wire logic                   neg,
	input  wire logic [AmpW-1:0]        amplitude,
	output logic      [SAMPLE_BITS-1:0] sample_q
);

	logic signed [SAMPLE_BITS-1:0]  sine;
	logic signed [AmpW:0]           amp_s;
	logic signed [SAMPLE_BITS+AmpW:0] prod;
	logic signed [SAMPLE_BITS+AmpW:0] scaled;

	assign sine   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	assign amp_s  = $signed({1'b0, amplitude});
	assign prod   = sine * amp_s;
	// Arithmetic shift floors towards minus infinity
	assign scaled = prod >>> AmpW;

	always_ff @(posedge clk) begin
		if (load)
			sample_q <= scaled[SAMPLE_BITS-1:0];
	end

endmodule

`default_nettype wire

/* src/sine_wavetable_oscillator.sv */
// Sine oscillator by direct digital synthesis.
// Input stream: each item carries sample_tick in s_tdata bit 0. An item with
// the tick high asks for the next sample; an item with the tick low is taken
// and dropped. While period_length is zero every item is dropped as well.
// Output stream: one item per requested sample, sample_value in m_tdata
// (signed, SAMPLE_BITS wide, zero padded to whole bytes) and period_start
// in m_tuser, high on position zero of the table period.
// Configuration: a write channel (cfg_valid/cfg_ready, cfg_index, cfg_data),
// always ready; write only while no item is in flight. Index 0 phase_step,
// 1 period_length, 2 amplitude; index 3 is ignored.
// Path: an accepted item reaches m_tvalid through three registers
// (phase register, table read register, multiplier output register).
// Throughput: one item per clock. Each stage advances whenever the stage
// after it is empty or moving, so a stalled receiver holds the output item
// while bubbles ahead of it still fill; s_tready falls only once every
// stage holds an item.
// Reset: registers return to their defaults, position and phase to zero,
// and the pipeline empties. The sine table is a constant ROM and needs no
// clearing pass.
`default_nettype none

module sine_wavetable_oscillator
	import swo_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SineTableBitsDef,
	parameter int SAMPLE_BITS     = SampleBitsDef
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [0] sample_tick
	// output stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // [SAMPLE_BITS-1:0] sample_value
	output logic                       m_tuser,   // [0] period_start
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CfgIndexW-1:0]  cfg_index,
	input  wire logic [31:0]           cfg_data
);

	localparam int TdataW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int AddrW  = SINE_TABLE_BITS - 1;

	// Configuration registers
	logic [PhaseW-1:0]  phase_step_q;
	logic [PeriodW-1:0] period_length_q;
	logic [AmpW-1:0]    amplitude_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= PhaseStepRst;
			period_length_q <= PeriodLengthRst;
			amplitude_q     <= AmplitudeRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PHASE_STEP:    phase_step_q    <= cfg_data;
				REG_PERIOD_LENGTH: period_length_q <= cfg_data[PeriodW-1:0];
				REG_AMPLITUDE:     amplitude_q     <= cfg_data[AmpW-1:0];
				default: ;
			endcase
		end
	end

	// Stage advance: each stage loads when the next one is empty or moving
	swo_ctl_t                   ctl_s1;
	swo_ctl_t                   ctl_s2;
	logic [SINE_TABLE_BITS-1:0] idx_s1;
	logic                       neg_s2;
	logic [SAMPLE_BITS-2:0]     mag_s2;
	logic [SAMPLE_BITS-1:0]     sample_q;
	logic                       start_q;
	logic                       adv1;
	logic                       adv2;
	logic                       adv3;
	logic                       in_acc;
	logic                       item;

	assign adv3     = !m_tvalid || m_tready;
	assign adv2     = !ctl_s2.valid || adv3;
	assign adv1     = !ctl_s1.valid || adv2;
	assign s_tready = adv1;
	assign in_acc   = s_tvalid && s_tready;
	// Only a tick with a nonzero period makes a sample
	assign item     = in_acc && s_tdata[0] && (period_length_q != '0);

	// Stage 1: position counter and phase accumulator
	swo_phase #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv1),
		.item         (item),
		.phase_step   (phase_step_q),
		.period_length(period_length_q),
		.ctl_s1       (ctl_s1),
		.idx_s1       (idx_s1)
	);

	// Stage 2: quarter-wave table read, mirrored in odd quadrants
	logic [1:0]       quad;
	logic [AddrW-1:0] off;
	logic [AddrW-1:0] rom_addr;

	assign quad     = idx_s1[SINE_TABLE_BITS-1 -: 2];
	assign off      = AddrW'(idx_s1[SINE_TABLE_BITS-3:0]);
	assign rom_addr = quad[0] ? (AddrW'(1) << (SINE_TABLE_BITS - 2)) - off : off;

	swo_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_rom (
		.clk    (clk),
		.rd_en  (adv2 && ctl_s1.valid),
		.rd_addr(rom_addr),
		.rd_data(mag_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2.valid <= 1'b0;
			ctl_s2.start <= 1'b0;
			neg_s2       <= 1'b0;
		end else if (adv2) begin
			ctl_s2.valid <= ctl_s1.valid;
			if (ctl_s1.valid) begin
				ctl_s2.start <= ctl_s1.start;
				// Negate in the lower half turn
				neg_s2       <= quad[1];
			end
		end
	end

	// Stage 3: sign, gain and output register
	swo_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk      (clk),
		.load     (adv3 && ctl_s2.valid),
		.mag      (mag_s2),
		.neg      (neg_s2),
		.amplitude(amplitude_q),
		.sample_q (sample_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv3)
			m_tvalid <= ctl_s2.valid;
	end

	always_ff @(posedge clk) begin
		if (adv3 && ctl_s2.valid)
			start_q <= ctl_s2.start;
	end

	assign m_tdata = TdataW'(sample_q);
	assign m_tuser = start_q;

	// A requested sample always enters the pipeline
	a_item_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item |=> ctl_s1.valid)
		else $error("requested sample did not enter stage 1");

	// Position zero always coincides with phase zero
	a_start_phase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && ctl_s1.start) |-> (idx_s1 == '0))
		else $error("period start with nonzero phase");

	// A stage 1 item moving on lands in stage 2
	a_stage2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && adv2) |=> ctl_s2.valid)
		else $error("stage 1 item lost");

	// Gain below one keeps the sample off the most negative code
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (sample_q != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
		else $error("sample exceeds full scale");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
	import swo_pkg::*;

	// Build of the block under test and derived sizes
	localparam int TableBits  = 10;
	localparam int SampleW    = 16;
	localparam int DataW      = ((SampleW + 7) / 8) * 8;
	localparam int QuarterLen = 1 << (TableBits - 2);
	localparam longint unsigned FullScale = (64'd1 << (SampleW - 1)) - 64'd1;

	// Index 3 has no register behind it; writes there must be ignored
	localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;

	// Pipeline is three stages deep; give dropped items time to leave it
	localparam int LatencyPause = 8;
	// Long receiver hold-off, long enough to fill every stage and stall the input
	localparam int HoldCycles   = 120;
	// Cycles with no handshake anywhere before the run is declared hung
	localparam int StallLimit   = 3000;
	localparam int SegmentItems = 130;

	typedef struct packed {
		logic signed [SampleW-1:0] value;
		logic                      start;
	} sample_t;

	// Predicts each sample from its own copy of the oscillator state and
	// compares the output stream against the queue of samples still owed.
	class sine_scoreboard;
		logic [31:0] step;
		logic [15:0] period;
		logic [14:0] gain;
		logic [15:0] pos;
		logic [31:0] phase;
		longint      quarter_wave [QuarterLen+1];
		sample_t     awaited [$];
		int          mismatches;
		int          samples;
		int          starts;
		int          ticks;
		int          dropped;
		int          writes;

		function new();
			longint unsigned angle;
			longint unsigned angle_sq;
			longint unsigned term;
			longint unsigned clamped;
			longint unsigned rounded;
			longint          acc;
			step   = 32'd2141543;
			period = 16'd100;
			gain   = 15'd32767;
			pos    = '0;
			phase  = '0;
			// quarter-wave table: Taylor series in Q30, then scaled and rounded
			for (int k = 0; k <= QuarterLen; k++) begin
				angle    = (64'(k) * 64'd1686629713) >> (TableBits - 2);
				angle_sq = (angle * angle) >> 30;
				term     = angle;
				acc      = longint'(angle);
				for (int n = 1; n <= 7; n++) begin
					term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
					if (n % 2 == 1)
						acc = acc - longint'(term);
					else
						acc = acc + longint'(term);
				end
				if (acc < 0)
					acc = 0;
				if (acc > longint'(64'd1 << 30))
					acc = longint'(64'd1 << 30);
				clamped = acc;
				rounded = (clamped * FullScale + (64'd1 << 29)) >> 30;
				if (rounded > FullScale)
					rounded = FullScale;
				quarter_wave[k] = longint'(rounded);
			end
		endfunction

		function void note_write(logic [CfgIndexW-1:0] idx, logic [31:0] data);
			writes++;
			case (idx)
				REG_PHASE_STEP:    step   = data;
				REG_PERIOD_LENGTH: period = data[15:0];
				REG_AMPLITUDE:     gain   = data[14:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic tick);
			logic [TableBits-1:0] addr;
			longint               mag;
			longint               prod;
			sample_t              item;
			if (!tick) begin
				dropped++;
				return;
			end
			ticks++;
			if (period == 0) begin
				dropped++;
				return;
			end
			// period run out or shortened: restart the table before sampling
			if (pos >= period) begin
				pos   = '0;
				phase = '0;
			end
			addr = phase[31 -: TableBits];
			// odd quadrants read the table backwards, the lower half negates
			if (addr[TableBits-2])
				mag = quarter_wave[QuarterLen - addr[TableBits-3:0]];
			else
				mag = quarter_wave[addr[TableBits-3:0]];
			if (addr[TableBits-1])
				mag = -mag;
			prod       = mag * longint'(gain);
			item.value = SampleW'(prod >>> 15);
			item.start = (pos == 0);
			awaited.push_back(item);
			pos   = pos + 16'd1;
			phase = phase + step;
		endfunction

		function void check_sample(logic [SampleW-1:0] value, logic start);
			sample_t want;
			samples++;
			if (start)
				starts++;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected sample, expected none, actual value %0d start %0b",
					$time, $signed(value), start);
				return;
			end
			want = awaited.pop_front();
			if (want.value !== value) begin
				mismatches++;
				$display("%0t: sample_value mismatch, expected %0d, actual %0d",
					$time, want.value, $signed(value));
			end
			if (want.start !== start) begin
				mismatches++;
				$display("%0t: period_start mismatch, expected %0b, actual %0b",
					$time, want.start, start);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;    // [0] sample_tick
	logic                 m_tvalid;
	logic                 m_tready;
	logic [DataW-1:0]     m_tdata;    // [SampleW-1:0] sample_value
	logic                 m_tuser;    // [0] period_start
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index;
	logic [31:0]          cfg_data;

	sine_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_asked   = 0;
	int holds_done    = 0;
	int quiet_cycles  = 0;

	sine_wavetable_oscillator #(
		.SINE_TABLE_BITS(TableBits),
		.SAMPLE_BITS    (SampleW)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Sample every handshake at the edge itself: predict on input items,
	// check output items, mirror register writes.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_item(s_tdata[0]);
		if (m_tvalid && m_tready)
			sb.check_sample(m_tdata[SampleW-1:0], m_tuser);
		if (cfg_valid && cfg_ready)
			sb.note_write(cfg_index, cfg_data);
	end

	// Watchdog: count cycles in which no item and no write moves
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("sine_wavetable_oscillator test failed");
			$finish;
		end
	end

	// Receiver: random back-pressure, or a long hold-off counted here when asked
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				holds_done++;
			end else
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one item, idling first at the sender's rate; leave tvalid high
	// on return so back-to-back items follow with no idle gap.
	task automatic offer_tick(input logic tick);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, tick};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_ticks(input int count, input int high_pct);
		for (int i = 0; i < count; i++)
			offer_tick($urandom_range(99) < high_pct);
	endtask

	// Hold the input until every owed sample is out, then let dropped
	// items clear the pipeline too. Drop tvalid and wait for an edge
	// first so the last accepted item is already noted.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (LatencyPause) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// New setting for a segment; upper data bits carry junk the block must drop
	task automatic random_settings();
		logic [31:0] new_step;
		logic [15:0] new_len;
		logic [14:0] new_gain;
		case ($urandom_range(2))
			0: new_step = $urandom_range(0, 32'h0100_0000);
			1: new_step = $urandom;
			default: new_step = 32'h8000_0000 >> $urandom_range(0, 12);
		endcase
		case ($urandom_range(19))
			0: new_len = 16'd0;
			1, 2, 3, 4, 5: new_len = 16'($urandom_range(1, 8));
			6, 7: new_len = 16'($urandom);
			default: new_len = 16'($urandom_range(1, 300));
		endcase
		case ($urandom_range(3))
			0: new_gain = 15'h7FFF;
			1: new_gain = 15'($urandom_range(0, 16));
			default: new_gain = 15'($urandom);
		endcase
		write_reg(REG_PHASE_STEP, new_step);
		write_reg(REG_PERIOD_LENGTH, {16'($urandom), new_len});
		write_reg(REG_AMPLITUDE, {17'($urandom), new_gain});
		if ($urandom_range(3) == 0)
			write_reg(RegUnused, $urandom);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PHASE_STEP;
		cfg_data  = '0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, with a dropped tick-low item among the ticks
		offer_tick(1'b1);
		offer_tick(1'b1);
		offer_tick(1'b1);
		offer_tick(1'b0);
		offer_tick(1'b1);
		offer_tick(1'b1);
		settle();

		// Zero period: every item dropped, state untouched
		write_reg(REG_PERIOD_LENGTH, 32'h0000_0000);
		offer_tick(1'b1);
		offer_tick(1'b1);
		offer_tick(1'b0);
		settle();

		// Period shorter than the current position: restart, then walk all
		// four quadrants a quarter turn at a time and wrap
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		write_reg(REG_PERIOD_LENGTH, 32'hFFFF_0004);
		send_ticks(6, 100);
		settle();

		// Largest step and period: the phase wraps modulo a full turn;
		// junk in the upper data bits and a write to the unused index
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_PERIOD_LENGTH, 32'h1234_FFFF);
		write_reg(REG_AMPLITUDE, 32'h5555_FFFF);
		write_reg(RegUnused, 32'hFFFF_FFFF);
		send_ticks(3, 100);
		settle();

		// Half-turn steps at zero gain, then at the smallest gain
		write_reg(REG_PHASE_STEP, 32'h8000_0000);
		write_reg(REG_AMPLITUDE, 32'h0000_8000);
		send_ticks(2, 100);
		settle();
		write_reg(REG_AMPLITUDE, 32'h0000_0001);
		send_ticks(2, 100);
		settle();

		// Period of one: every sample opens a period
		write_reg(REG_PERIOD_LENGTH, 32'h0000_0001);
		send_ticks(3, 100);
		settle();

		// Back-pressure: hold the receiver off while items keep coming
		write_reg(REG_PERIOD_LENGTH, 32'h0000_0040);
		write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
		write_reg(REG_PHASE_STEP, 32'h0400_0000);
		holds_asked++;
		send_ticks(40, 100);
		settle();

		// Random segments: receiver-idle-heavy, sender-idle-heavy, then free flow
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 85 : 0;
			recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 22 : 0;
			for (int seg = 0; seg < 5; seg++) begin
				random_settings();
				send_ticks(SegmentItems, 85);
				settle();
			end
		end

		$display("Run covered %0d ticks, %0d dropped items, %0d samples, %0d period starts.",
			sb.ticks, sb.dropped, sb.samples, sb.starts);
		$display("It made %0d register writes over zero, unit and full periods and gains.",
			sb.writes);
		if (sb.mismatches == 0)
			$display("sine_wavetable_oscillator test passed");
		else
			$display("sine_wavetable_oscillator test failed");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
src/swo_pkg.sv
src/swo_phase.sv
src/swo_rom.sv
src/swo_scale.sv
src/sine_wavetable_oscillator.sv
sim/testbench.sv
